FILE: rtl/stepseq_pkg.sv
// Shared constants, types and pattern lookup for the stepper command sequencer.
package stepseq_pkg;

   // Default build values.
   localparam int STEPSEQ_REPEATS   = 12;
   localparam int STEPSEQ_DELAY_MAX = 100;

   // Delay bounds and reset value.
   localparam logic [6:0] DELAY_MIN   = 7'd2;
   localparam logic [6:0] DELAY_RESET = 7'd20;
   localparam logic [6:0] DELAY_STEP  = 7'd2;

   // Command characters.
   localparam logic [7:0] CMD_DELAY_UP   = 8'h71;  // q
   localparam logic [7:0] CMD_DELAY_DOWN = 8'h77;  // w
   localparam logic [7:0] CMD_RUN_FWD    = 8'h65;  // e
   localparam logic [7:0] CMD_RUN_BWD    = 8'h72;  // r
   localparam logic [7:0] CMD_DIR_FWD    = 8'h31;  // 1
   localparam logic [7:0] CMD_DIR_BWD    = 8'h32;  // 2
   localparam logic [7:0] CMD_STOP       = 8'h30;  // 0
   localparam logic [7:0] CMD_MODE_FULL  = 8'h61;  // a
   localparam logic [7:0] CMD_MODE_HALF  = 8'h73;  // s
   localparam logic [7:0] CMD_MODE_WAVE  = 8'h64;  // d

   // Operation codes on the request channel.
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Step modes.
   localparam logic [1:0] MODE_FULL = 2'd1;
   localparam logic [1:0] MODE_HALF = 2'd2;
   localparam logic [1:0] MODE_WAVE = 2'd3;

   // Direction codes.
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BWD  = 2'd2;

   // Coil patterns, bit3 A1, bit2 A2, bit1 B1, bit0 B2.
   localparam logic [3:0] FULL_TAB [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
   localparam logic [3:0] HALF_TAB [8] = '{4'hA, 4'h2, 4'h6, 4'h4,
                                           4'h5, 4'h1, 4'h9, 4'h8};
   localparam logic [3:0] WAVE_TAB [4] = '{4'h8, 4'h2, 4'h4, 4'h1};

   // Everything one result item reports.
   typedef struct packed {
      logic [3:0] coil;
      logic [1:0] direction;
      logic [1:0] mode;
      logic [6:0] delay;
      logic       busy;
      logic       limit;
   } stepseq_status_type;

   // Coil pattern for a phase; a backward run walks the table from its end.
   function automatic logic [3:0] pattern_at(input logic [1:0] mode,
                                             input logic       reverse,
                                             input logic [2:0] phase);
      logic [2:0] idx;
      logic [3:0] pat;
      idx = (mode == MODE_HALF) ? phase : {1'b0, phase[1:0]};
      if (reverse) begin
         idx = (mode == MODE_HALF) ? ~idx : {1'b0, ~idx[1:0]};
      end
      case (mode)
         MODE_HALF: pat = HALF_TAB[idx];
         MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
         default:   pat = FULL_TAB[idx[1:0]];
      endcase
      return pat;
   endfunction

endpackage

FILE: rtl/stepseq_if.sv
// Valid/ready channel interfaces for the request and response items.
interface stepseq_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] command_char;

   modport source (output valid, output operation, output command_char, input ready);
   modport sink   (input valid, input operation, input command_char, output ready);
endinterface

interface stepseq_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coil_pattern;
   logic [1:0] drive_direction;
   logic [1:0] step_mode;
   logic [6:0] delay_now;
   logic       run_busy;
   logic       limit_hit;

   modport source (output valid, output coil_pattern, output drive_direction,
                   output step_mode, output delay_now, output run_busy,
                   output limit_hit, input ready);
   modport sink   (input valid, input coil_pattern, input drive_direction,
                   input step_mode, input delay_now, input run_busy,
                   input limit_hit, output ready);
endinterface

FILE: rtl/stepseq_core.sv
// Sequencer state registers and the per-item command and tick logic.
module stepseq_core
   import stepseq_pkg::*;
#(
   parameter int REPEATS   = STEPSEQ_REPEATS,
   parameter int DELAY_MAX = STEPSEQ_DELAY_MAX
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               operation,
   input  logic [7:0]         command_char,
   output stepseq_status_type next_status
);

   localparam logic [8:0] RepeatsW  = 9'(REPEATS);
   localparam logic [7:0] DelayMaxW = 8'(DELAY_MAX);

   logic [6:0] delay_ff,  delay_in;
   logic [1:0] mode_ff,   mode_in;
   logic [1:0] dir_ff,    dir_in;
   logic [3:0] coil_ff,   coil_in;
   logic       busy_ff,   busy_in;
   logic       rev_ff,    rev_in;
   logic [2:0] phase_ff,  phase_in;
   logic [7:0] repeat_ff, repeat_in;
   logic [6:0] tick_ff,   tick_in;
   logic       limit_in;
   logic [3:0] seq_len;

   assign seq_len = (mode_ff == MODE_HALF) ? 4'd8 : 4'd4;

   // Next state for one accepted item.
   always_comb begin
      delay_in  = delay_ff;
      mode_in   = mode_ff;
      dir_in    = dir_ff;
      coil_in   = coil_ff;
      busy_in   = busy_ff;
      rev_in    = rev_ff;
      phase_in  = phase_ff;
      repeat_in = repeat_ff;
      tick_in   = tick_ff;
      limit_in  = 1'b0;
      if (step_en) begin
         if (operation == OP_TICK) begin
            if (busy_ff) begin
               if ({1'b0, tick_ff} + 8'd1 < {1'b0, delay_ff}) begin
                  tick_in = tick_ff + 7'd1;
               end else begin
                  tick_in = '0;
                  if ({1'b0, phase_ff} + 4'd1 < seq_len) begin
                     phase_in = phase_ff + 3'd1;
                     coil_in  = pattern_at(mode_ff, rev_ff, phase_ff + 3'd1);
                  end else begin
                     phase_in = '0;
                     if ({1'b0, repeat_ff} + 9'd1 >= RepeatsW) begin
                        repeat_in = '0;
                        busy_in   = 1'b0;
                        dir_in    = DIR_STOP;
                     end else begin
                        repeat_in = repeat_ff + 8'd1;
                        coil_in   = pattern_at(mode_ff, rev_ff, 3'd0);
                     end
                  end
               end
            end
         end else if (!busy_ff) begin
            case (command_char)
               CMD_DELAY_UP: begin
                  if ({1'b0, delay_ff} + {1'b0, DELAY_STEP} <= DelayMaxW) begin
                     delay_in = delay_ff + DELAY_STEP;
                  end else begin
                     limit_in = 1'b1;
                  end
               end
               CMD_DELAY_DOWN: begin
                  if (delay_ff > DELAY_MIN) begin
                     delay_in = delay_ff - DELAY_STEP;
                  end else begin
                     limit_in = 1'b1;
                  end
               end
               CMD_MODE_FULL: mode_in = MODE_FULL;
               CMD_MODE_HALF: mode_in = MODE_HALF;
               CMD_MODE_WAVE: mode_in = MODE_WAVE;
               CMD_DIR_FWD:   dir_in  = DIR_FWD;
               CMD_DIR_BWD:   dir_in  = DIR_BWD;
               CMD_STOP: begin
                  dir_in  = DIR_STOP;
                  coil_in = '0;
               end
               CMD_RUN_FWD, CMD_RUN_BWD: begin
                  busy_in   = 1'b1;
                  rev_in    = (command_char == CMD_RUN_BWD);
                  phase_in  = '0;
                  repeat_in = '0;
                  tick_in   = '0;
                  coil_in   = pattern_at(mode_ff, command_char == CMD_RUN_BWD, 3'd0);
               end
               default: ;
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         mode_ff   <= MODE_FULL;
         dir_ff    <= DIR_STOP;
         coil_ff   <= '0;
         busy_ff   <= 1'b0;
         rev_ff    <= 1'b0;
         phase_ff  <= '0;
         repeat_ff <= '0;
         tick_ff   <= '0;
      end else begin
         delay_ff  <= delay_in;
         mode_ff   <= mode_in;
         dir_ff    <= dir_in;
         coil_ff   <= coil_in;
         busy_ff   <= busy_in;
         rev_ff    <= rev_in;
         phase_ff  <= phase_in;
         repeat_ff <= repeat_in;
         tick_ff   <= tick_in;
      end
   end

   // The result reports the state after the item.
   assign next_status = '{coil: coil_in, direction: dir_in, mode: mode_in,
                          delay: delay_in, busy: busy_in, limit: limit_in};

   // The end of a run always leaves the motor stopped.
   a_run_end_stops: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> dir_ff == DIR_STOP)
      else $error("run ended without clearing the direction");

   // The delay never leaves its legal range.
   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      delay_ff >= DELAY_MIN && {1'b0, delay_ff} <= DelayMaxW)
      else $error("step delay out of range");

   // During a run the tick counter stays below the delay.
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> tick_ff < delay_ff)
      else $error("tick count reached the delay");

   // During a run the phase and repeat counters stay within their sequence.
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, phase_ff} < seq_len && {1'b0, repeat_ff} < RepeatsW))
      else $error("phase or repeat count out of range");

endmodule

FILE: rtl/stepper_command_sequencer_unit.sv
// Top level of the stepper command sequencer with its response register.
//
// Usage: req_chan carries items that are either a command byte (operation 0,
// command_char holds the ASCII code) or a one-millisecond tick (operation 1).
// Every accepted item yields exactly one item on rsp_chan, reporting the coil
// pattern, direction code, step mode, step delay, run flag and limit flag as
// they stand after that item.
// Responses are registered: an item accepted at a clock edge has its response
// valid right after that edge. The unit takes one item per cycle while the
// receiver keeps up, set by the single response register; the sequencer state
// updates in the same cycle the item is accepted.
// When the receiver stalls, the response register holds its item and
// req_chan.ready drops until that item is taken; ready is high whenever the
// register is empty or being emptied in the same cycle.
// Synchronous reset restores delay 20, full-step mode, stopped direction,
// coils off and no run in progress, and empties the response register.
module stepper_command_sequencer_unit
   import stepseq_pkg::*;
#(
   parameter int REPEATS   = STEPSEQ_REPEATS,
   parameter int DELAY_MAX = STEPSEQ_DELAY_MAX
) (
   input  logic          clock,
   input  logic          reset,
   stepseq_req_if.sink   req_chan,
   stepseq_rsp_if.source rsp_chan
);

   logic               accept;
   logic               rsp_valid_ff, rsp_valid_in;
   stepseq_status_type status_ff;
   stepseq_status_type next_status;

   // Take a new item whenever the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   stepseq_core #(
      .REPEATS   (REPEATS),
      .DELAY_MAX (DELAY_MAX)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .operation    (req_chan.operation),
      .command_char (req_chan.command_char),
      .next_status  (next_status)
   );

   // Response valid flag.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on each accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= next_status;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.coil_pattern    = status_ff.coil;
   assign rsp_chan.drive_direction = status_ff.direction;
   assign rsp_chan.step_mode       = status_ff.mode;
   assign rsp_chan.delay_now       = status_ff.delay;
   assign rsp_chan.run_busy        = status_ff.busy;
   assign rsp_chan.limit_hit       = status_ff.limit;

endmodule
